@@ design/kdt_pkg.sv @@
// shared constants, codes and types for the key to dense id table
package kdt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_W       = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 3;

    localparam logic [MODE_W-1:0] MODE_LOOKUP     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP_ADD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STRICT_ADD = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ_INDEX = 2'd3;

    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd5;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [KEY_W-1:0] data;
    } wr_cmd_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] slot;
    } cam_result_t;

endpackage

@@ design/kdt_cam.sv @@
// key cells with a parallel compare against every held key
module kdt_cam
(
    input  logic                         clk,
    input  kdt_pkg::wr_cmd_t             wr,
    input  logic [kdt_pkg::CNT_W-1:0]    count,
    input  logic [kdt_pkg::KEY_W-1:0]    key,
    output kdt_pkg::cam_result_t         result
);

    logic [kdt_pkg::KEY_W-1:0]       cell_reg [kdt_pkg::TABLE_DEPTH];
    logic [kdt_pkg::TABLE_DEPTH-1:0] match;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            cell_reg[wr.addr] <= wr.data;
        end
    end

    // only slots below the count are live
    always_comb
    begin
        for (int i = 0; i < kdt_pkg::TABLE_DEPTH; i++)
        begin
            match[i] = (kdt_pkg::CNT_W'(i) < count) && (cell_reg[i] == key);
        end
    end

    // held keys are unique, so at most one match is set
    always_comb
    begin
        result.hit  = |match;
        result.slot = '0;
        for (int i = 0; i < kdt_pkg::TABLE_DEPTH; i++)
        begin
            if (match[i])
            begin
                result.slot = result.slot | kdt_pkg::IDX_W'(i);
            end
        end
    end

endmodule

@@ design/kdt_key_ram.sv @@
// key copy memory for read by index, registered read with write bypass
module kdt_key_ram
(
    input  logic                         clk,
    input  kdt_pkg::wr_cmd_t             wr,
    input  logic                         rd_en,
    input  logic [kdt_pkg::IDX_W-1:0]    rd_addr,
    output logic [kdt_pkg::KEY_W-1:0]    rd_data
);

    logic [kdt_pkg::KEY_W-1:0] mem [kdt_pkg::TABLE_DEPTH];
    logic [kdt_pkg::KEY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.en && (wr.addr == rd_addr))
            begin
                rd_data_reg <= wr.data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/key_to_dense_id_table.sv @@
// top level: interning table that assigns dense ids to 64-bit keys
// an accepted beat is held in the input register, then its result is written to the result register
// throughput: one beat per cycle while out_stall is low, set by the single pass from input to result register
// the parallel key compare and the key copy memory read both fit in that one pass
// reset clears the entry count and the valid flags; key storage is not cleared
module key_to_dense_id_table
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [kdt_pkg::MODE_W-1:0]      mode,
    input  logic [kdt_pkg::KEY_W-1:0]       key,
    input  logic [5:0]                      index,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [kdt_pkg::STATUS_W-1:0]    status,
    output logic [5:0]                      ident,
    output logic [kdt_pkg::KEY_W-1:0]       key_out,
    output logic [6:0]                      entries
);

    logic                            in_valid_reg;
    logic [kdt_pkg::MODE_W-1:0]      mode_reg;
    logic [kdt_pkg::KEY_W-1:0]       key_reg;
    logic [kdt_pkg::IDX_W-1:0]       index_reg;
    logic [kdt_pkg::CNT_W-1:0]       count_reg;
    logic [kdt_pkg::CNT_W-1:0]       count_next;
    logic                            out_valid_reg;
    logic [kdt_pkg::STATUS_W-1:0]    status_reg;
    logic [kdt_pkg::STATUS_W-1:0]    status_next;
    logic [kdt_pkg::IDX_W-1:0]       ident_reg;
    logic [kdt_pkg::IDX_W-1:0]       ident_next;
    logic [kdt_pkg::KEY_W-1:0]       key_out_reg;
    logic [kdt_pkg::KEY_W-1:0]       key_out_next;
    logic [kdt_pkg::CNT_W-1:0]       entries_reg;

    logic                            accept;
    logic                            advance;
    logic                            add;
    logic                            full;
    logic                            index_ok;
    logic [kdt_pkg::KEY_W-1:0]       rd_key;
    kdt_pkg::wr_cmd_t                wr;
    kdt_pkg::cam_result_t            cam;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            key_reg   <= key;
            index_reg <= index;
        end
    end

    kdt_cam u_cam
    (
        .clk    (clk),
        .wr     (wr),
        .count  (count_reg),
        .key    (key_reg),
        .result (cam)
    );

    // read is launched with the incoming beat so data lines up with the input register
    kdt_key_ram u_key_ram
    (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (accept),
        .rd_addr (index),
        .rd_data (rd_key)
    );

    assign full     = (count_reg == kdt_pkg::CNT_W'(kdt_pkg::TABLE_DEPTH));
    assign index_ok = (kdt_pkg::CNT_W'(index_reg) < count_reg);

    always_comb
    begin
        add          = 1'b0;
        status_next  = kdt_pkg::ST_NOT_FOUND;
        ident_next   = '0;
        key_out_next = '0;
        unique case (mode_reg) inside
            kdt_pkg::MODE_READ_INDEX:
            begin
                if (index_ok)
                begin
                    status_next  = kdt_pkg::ST_FOUND;
                    ident_next   = index_reg;
                    key_out_next = rd_key;
                end
                else
                begin
                    status_next = kdt_pkg::ST_BAD_INDEX;
                end
            end
            kdt_pkg::MODE_LOOKUP:
            begin
                if (cam.hit)
                begin
                    status_next = kdt_pkg::ST_FOUND;
                    ident_next  = cam.slot;
                end
            end
            kdt_pkg::MODE_LOOKUP_ADD,
            kdt_pkg::MODE_STRICT_ADD:
            begin
                if (cam.hit)
                begin
                    status_next = (mode_reg == kdt_pkg::MODE_STRICT_ADD) ?
                                  kdt_pkg::ST_DUPLICATE : kdt_pkg::ST_FOUND;
                    ident_next  = cam.slot;
                end
                else if (full)
                begin
                    status_next = kdt_pkg::ST_FULL;
                end
                else
                begin
                    add         = 1'b1;
                    status_next = kdt_pkg::ST_ADDED;
                    ident_next  = count_reg[kdt_pkg::IDX_W-1:0];
                end
            end
            default:
            begin
                status_next = kdt_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    assign wr.en   = advance && add;
    assign wr.addr = count_reg[kdt_pkg::IDX_W-1:0];
    assign wr.data = key_reg;

    assign count_next = wr.en ? (count_reg + kdt_pkg::CNT_W'(1)) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg  <= status_next;
            ident_reg   <= ident_next;
            key_out_reg <= key_out_next;
            entries_reg <= count_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign ident     = ident_reg;
    assign key_out   = key_out_reg;
    assign entries   = entries_reg;

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= kdt_pkg::CNT_W'(kdt_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_added_ident : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == kdt_pkg::ST_ADDED)) |->
        (kdt_pkg::CNT_W'(ident_reg) == (entries_reg - kdt_pkg::CNT_W'(1))))
        else $error("added beat ident does not match last slot");

    a_key_out_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (key_out_reg != '0)) |-> (status_reg == kdt_pkg::ST_FOUND))
        else $error("key_out set on a beat that is not a found result");

    a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + 1'b1))
        else $error("entry count moved by other than one");
`endif

endmodule

@@ bench/testbench.sv @@
// self-checking bench for key_to_dense_id_table: directed table, random beats, interning predictor
module testbench;

    typedef struct packed {
        logic [kdt_pkg::STATUS_W-1:0] status;
        logic [kdt_pkg::IDX_W-1:0]    ident;
        logic [kdt_pkg::KEY_W-1:0]    key_out;
        logic [kdt_pkg::CNT_W-1:0]    entries;
    } id_result_t;

    typedef struct {
        logic [kdt_pkg::MODE_W-1:0] mode;
        logic [kdt_pkg::KEY_W-1:0]  key;
        logic [kdt_pkg::IDX_W-1:0]  index;
        bit                         typed;
        id_result_t                 want;
    } dir_row_t;

    localparam int DIR_ROWS     = 18;
    localparam int RANDOM_BEATS = 650;
    localparam int WANT_DEPTH   = 1024;

    logic                         clk;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    logic [kdt_pkg::MODE_W-1:0]   mode      = kdt_pkg::MODE_LOOKUP;
    logic [kdt_pkg::KEY_W-1:0]    key       = '0;
    logic [5:0]                   index     = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [kdt_pkg::STATUS_W-1:0] status;
    logic [5:0]                   ident;
    logic [kdt_pkg::KEY_W-1:0]    key_out;
    logic [6:0]                   entries;

    // typed expectation travels with the beat it belongs to
    bit                           beat_typed = 1'b0;
    id_result_t                   beat_want  = '0;

    logic [kdt_pkg::KEY_W-1:0]    held_keys [kdt_pkg::TABLE_DEPTH];
    logic [kdt_pkg::CNT_W-1:0]    held_count = '0;
    // expected results in order of acceptance, never wraps over a run
    id_result_t                   want_fifo [WANT_DEPTH];
    int                           want_wr        = 0;
    int                           want_rd        = 0;
    dir_row_t                     dir_rows [DIR_ROWS];
    int                           mismatch_count = 0;
    int                           result_count   = 0;
    int                           send_calm      = 0;
    int                           sink_calm      = 0;

    key_to_dense_id_table dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .key       (key),
        .index     (index),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .ident     (ident),
        .key_out   (key_out),
        .entries   (entries)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // applies one request to the bench copy of the table and returns its result
    function automatic id_result_t intern_request(input logic [kdt_pkg::MODE_W-1:0] m,
                                                  input logic [kdt_pkg::KEY_W-1:0] k,
                                                  input logic [kdt_pkg::IDX_W-1:0] idx);
        id_result_t r;
        bit         hit;
        int         slot;
        r    = '0;
        hit  = 1'b0;
        slot = 0;
        if (m == kdt_pkg::MODE_READ_INDEX)
        begin
            if (kdt_pkg::CNT_W'(idx) < held_count)
            begin
                r.status  = kdt_pkg::ST_FOUND;
                r.ident   = idx;
                r.key_out = held_keys[idx];
            end
            else
                r.status = kdt_pkg::ST_BAD_INDEX;
        end
        else
        begin
            for (int i = 0; i < held_count; i++)
            begin
                if (!hit && held_keys[i] == k)
                begin
                    hit  = 1'b1;
                    slot = i;
                end
            end
            if (hit)
            begin
                r.status = (m == kdt_pkg::MODE_STRICT_ADD) ?
                           kdt_pkg::ST_DUPLICATE : kdt_pkg::ST_FOUND;
                r.ident  = slot[kdt_pkg::IDX_W-1:0];
            end
            else if (m == kdt_pkg::MODE_LOOKUP)
                r.status = kdt_pkg::ST_NOT_FOUND;
            else if (held_count >= kdt_pkg::TABLE_DEPTH)
                r.status = kdt_pkg::ST_FULL;
            else
            begin
                held_keys[held_count[kdt_pkg::IDX_W-1:0]] = k;
                r.ident    = held_count[kdt_pkg::IDX_W-1:0];
                held_count = held_count + 1'b1;
                r.status   = kdt_pkg::ST_ADDED;
            end
        end
        r.entries = held_count;
        return r;
    endfunction

    function automatic dir_row_t dir_row(input logic [kdt_pkg::MODE_W-1:0] m,
                                         input logic [kdt_pkg::KEY_W-1:0] k,
                                         input logic [kdt_pkg::IDX_W-1:0] idx, input bit typed,
                                         input logic [kdt_pkg::STATUS_W-1:0] st,
                                         input logic [kdt_pkg::IDX_W-1:0] id,
                                         input logic [kdt_pkg::KEY_W-1:0] ko,
                                         input logic [kdt_pkg::CNT_W-1:0] ent);
        dir_row_t row;
        row.mode    = m;
        row.key     = k;
        row.index   = idx;
        row.typed   = typed;
        row.want    = '{st, id, ko, ent};
        return row;
    endfunction

    // mostly short gaps, a few long ones, and now and then a calm stretch with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 40);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        // lines beyond the first 200 are counted only
        if (mismatch_count < 200)
            $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h expected %0h",
                                      result_count, name, got, want));
    endtask

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_beat(input logic [kdt_pkg::MODE_W-1:0] m,
                             input logic [kdt_pkg::KEY_W-1:0] k,
                             input logic [kdt_pkg::IDX_W-1:0] idx, input bit typed,
                             input id_result_t want);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        key        <= k;
        index      <= idx;
        beat_typed <= typed;
        beat_want  <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : watch
        id_result_t predicted;
        id_result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predicted = intern_request(mode, key, index);
                want_fifo[want_wr] = beat_typed ? beat_want : predicted;
                want_wr++;
            end
            if (out_valid && !out_stall)
            begin
                if (want_rd == want_wr)
                    report_mismatch($sformatf("result %0d with nothing expected: status %0d",
                                              result_count, status));
                else
                begin
                    want = want_fifo[want_rd];
                    want_rd++;
                    check_field("status", status, want.status);
                    check_field("ident", ident, want.ident);
                    check_field("key_out", key_out, want.key_out);
                    check_field("entries", entries, want.entries);
                end
                result_count++;
            end
        end
    end

    initial
    begin
        int run;
        @(posedge rst_n);
        forever
        begin
            run = pick_gap(sink_calm);
            if (run > 0)
            begin
                out_stall <= 1'b1;
                repeat (run) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial
    begin
        logic [kdt_pkg::MODE_W-1:0] m;
        logic [kdt_pkg::KEY_W-1:0]  k;
        logic [kdt_pkg::IDX_W-1:0]  idx;
        int                         r;
        int                         cnt;
        int                         b;

        // empty table, the key extremes, hits, misses, duplicate and index bounds
        dir_rows[0]  = dir_row(kdt_pkg::MODE_LOOKUP, 64'h0, 6'd0, 1,
                               kdt_pkg::ST_NOT_FOUND, 6'd0, 64'h0, 7'd0);
        dir_rows[1]  = dir_row(kdt_pkg::MODE_READ_INDEX, 64'h0, 6'd0, 1,
                               kdt_pkg::ST_BAD_INDEX, 6'd0, 64'h0, 7'd0);
        dir_rows[2]  = dir_row(kdt_pkg::MODE_READ_INDEX, '1, 6'd63, 1,
                               kdt_pkg::ST_BAD_INDEX, 6'd0, 64'h0, 7'd0);
        dir_rows[3]  = dir_row(kdt_pkg::MODE_STRICT_ADD, 64'h0, 6'd0, 1,
                               kdt_pkg::ST_ADDED, 6'd0, 64'h0, 7'd1);
        dir_rows[4]  = dir_row(kdt_pkg::MODE_LOOKUP_ADD, '1, 6'd63, 1,
                               kdt_pkg::ST_ADDED, 6'd1, 64'h0, 7'd2);
        dir_rows[5]  = dir_row(kdt_pkg::MODE_LOOKUP, '1, 6'd0, 1,
                               kdt_pkg::ST_FOUND, 6'd1, 64'h0, 7'd2);
        dir_rows[6]  = dir_row(kdt_pkg::MODE_STRICT_ADD, '1, 6'd0, 1,
                               kdt_pkg::ST_DUPLICATE, 6'd1, 64'h0, 7'd2);
        dir_rows[7]  = dir_row(kdt_pkg::MODE_LOOKUP_ADD, 64'h0, 6'd0, 1,
                               kdt_pkg::ST_FOUND, 6'd0, 64'h0, 7'd2);
        dir_rows[8]  = dir_row(kdt_pkg::MODE_READ_INDEX, 64'h0, 6'd1, 1,
                               kdt_pkg::ST_FOUND, 6'd1, '1, 7'd2);
        dir_rows[9]  = dir_row(kdt_pkg::MODE_READ_INDEX, 64'h0, 6'd2, 1,
                               kdt_pkg::ST_BAD_INDEX, 6'd0, 64'h0, 7'd2);
        dir_rows[10] = dir_row(kdt_pkg::MODE_LOOKUP, 64'h8000_0000_0000_0000, 6'd0, 1,
                               kdt_pkg::ST_NOT_FOUND, 6'd0, 64'h0, 7'd2);
        dir_rows[11] = dir_row(kdt_pkg::MODE_STRICT_ADD, 64'h8000_0000_0000_0000, 6'd0, 1,
                               kdt_pkg::ST_ADDED, 6'd2, 64'h0, 7'd3);
        dir_rows[12] = dir_row(kdt_pkg::MODE_LOOKUP, 64'h7fff_ffff_ffff_ffff, 6'd0, 1,
                               kdt_pkg::ST_NOT_FOUND, 6'd0, 64'h0, 7'd3);
        dir_rows[13] = dir_row(kdt_pkg::MODE_LOOKUP_ADD, 64'h0123_4567_89ab_cdef, 6'd21, 0,
                               kdt_pkg::ST_FOUND, 6'd0, 64'h0, 7'd0);
        dir_rows[14] = dir_row(kdt_pkg::MODE_READ_INDEX, 64'hffff, 6'd3, 0,
                               kdt_pkg::ST_FOUND, 6'd0, 64'h0, 7'd0);
        dir_rows[15] = dir_row(kdt_pkg::MODE_LOOKUP, 64'h1, 6'd63, 1,
                               kdt_pkg::ST_NOT_FOUND, 6'd0, 64'h0, 7'd4);
        dir_rows[16] = dir_row(kdt_pkg::MODE_STRICT_ADD, 64'h0123_4567_89ab_cdef, 6'd0, 0,
                               kdt_pkg::ST_FOUND, 6'd0, 64'h0, 7'd0);
        dir_rows[17] = dir_row(kdt_pkg::MODE_READ_INDEX, '1, 6'd0, 1,
                               kdt_pkg::ST_FOUND, 6'd0, 64'h0, 7'd4);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_beat(dir_rows[i].mode, dir_rows[i].key, dir_rows[i].index,
                      dir_rows[i].typed, dir_rows[i].want);

        // new keys arrive often enough that the table fills early on, so the
        // later beats exercise the full table and duplicate ahead of full
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            r   = $urandom_range(0, 99);
            m   = kdt_pkg::MODE_W'($urandom_range(0, 2));
            k   = {$urandom, $urandom};
            idx = kdt_pkg::IDX_W'($urandom_range(0, 63));
            cnt = held_count;
            if (r < 20)
            begin
                m = kdt_pkg::MODE_READ_INDEX;
                if (cnt > 0 && $urandom_range(0, 1))
                    idx = kdt_pkg::IDX_W'($urandom_range(0, cnt - 1));
            end
            else if (cnt > 0 && r < 65)
                k = held_keys[kdt_pkg::IDX_W'($urandom_range(0, cnt - 1))];
            else if (cnt > 0 && r < 80)
            begin
                // near miss: a held key with one bit flipped
                k    = held_keys[kdt_pkg::IDX_W'($urandom_range(0, cnt - 1))];
                b    = $urandom_range(0, kdt_pkg::KEY_W - 1);
                k[b] = ~k[b];
            end
            send_beat(m, k, idx, 1'b0, '0);
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (want_rd != want_wr)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (want_rd != want_wr)
            report_mismatch($sformatf("%0d results never arrived", want_wr - want_rd));

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ key_to_dense_id_table.f @@
design/kdt_pkg.sv
design/kdt_cam.sv
design/kdt_key_ram.sv
design/key_to_dense_id_table.sv
bench/testbench.sv
